>>> hdl/bpc_pkg.sv
// Shared constants and widths for the barometric pressure compensation pipeline.
package bpc_pkg;

    // Calibration register indexes
    localparam int unsigned CFG_PRESSURE_SENS   = 0;
    localparam int unsigned CFG_PRESSURE_OFFSET = 1;
    localparam int unsigned CFG_SENS_TEMP_COEFF = 2;
    localparam int unsigned CFG_OFF_TEMP_COEFF  = 3;
    localparam int unsigned CFG_REFERENCE_TEMP  = 4;
    localparam int unsigned CFG_TEMP_COEFF      = 5;
    localparam int unsigned CFG_N               = 6;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CAL_W     = 16;
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned TEMP_O_W  = 15;
    localparam int unsigned PRES_O_W  = 18;

    // Internal widths
    localparam int unsigned DT_W   = 25;  // signed temperature difference
    localparam int unsigned LP_W   = 42;  // dT times a calibration word
    localparam int unsigned DD_W   = 50;  // dT squared
    localparam int unsigned T_W    = 20;  // temperature before clamping
    localparam int unsigned ACC_W  = 40;  // offset, sensitivity and corrections
    localparam int unsigned HALF_W = 20;  // sensitivity split for the pressure multiply
    localparam int unsigned PP_W   = 46;  // partial products
    localparam int unsigned PROD_W = 64;  // D1 times sensitivity
    localparam int unsigned X_W    = 43;  // pressure before the final shift

    localparam int unsigned NSTG = 9;     // pipeline depth, output register included

    localparam logic signed [T_W-1:0] TEMP_REF    = 20'sd2000;
    localparam logic signed [T_W-1:0] TEMP_COLD   = 20'sd1500;
    localparam logic signed [T_W-1:0] TEMP_SAT_LO = -20'sd4000;
    localparam logic signed [T_W-1:0] TEMP_SAT_HI = 20'sd8500;

endpackage

>>> hdl/barometric_pressure_compensation.sv
// Top level: nine-stage pipelined barometer temperature and pressure compensation.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_raw_pressure, i_raw_temperature
//  output   | o_out_valid  | i_out_stall  | o_temperature, o_pressure
//  config   | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_in_stall is low; the last stage is the output register.
// The depth is set by the multiplier chain: dT products, squares, then the split
// D1 x SENS multiply.
// Each stage holds its item only while the next one is full and stalled, so bubbles close up.
// Synchronous active-low reset clears valid bits and the calibration words.
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CAL_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [RAW_W-1:0]              i_raw_pressure,
    input  logic [RAW_W-1:0]              i_raw_temperature,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [TEMP_O_W-1:0]    o_temperature,
    output logic [PRES_O_W-1:0]           o_pressure
);

    logic [CAL_W-1:0] r_cal [CFG_N];

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    // stage 1
    logic signed [DT_W-1:0]   r_s1_dt, n_s1_dt;
    logic [RAW_W-1:0]         r_s1_d1;
    // stage 2
    logic signed [LP_W-1:0]   r_p_c6, r_p_c4, r_p_c3, n_p_c6, n_p_c4, n_p_c3;
    logic signed [DD_W-1:0]   r_p_dd, n_p_dd;
    logic [RAW_W-1:0]         r_s2_d1;
    // stage 3
    logic signed [T_W-1:0]    r_s3_temp, n_s3_temp, r_s3_t2, n_s3_t2;
    logic signed [ACC_W-1:0]  r_s3_off, n_s3_off, r_s3_sens, n_s3_sens;
    logic [RAW_W-1:0]         r_s3_d1;
    // stage 4
    logic signed [T_W-1:0]    diff_a, diff_b;
    logic signed [ACC_W-1:0]  r_s4_a, n_s4_a, r_s4_b, n_s4_b;
    logic                     r_s4_lt, r_s4_cold;
    logic signed [T_W-1:0]    r_s4_temp, r_s4_t2;
    logic signed [ACC_W-1:0]  r_s4_off, r_s4_sens;
    logic [RAW_W-1:0]         r_s4_d1;
    // stage 5
    logic signed [ACC_W-1:0]  r_s5_off2, n_s5_off2, r_s5_sens2, n_s5_sens2;
    logic signed [T_W-1:0]    r_s5_temp, n_s5_temp;
    logic signed [ACC_W-1:0]  r_s5_off, r_s5_sens;
    logic [RAW_W-1:0]         r_s5_d1;
    // stage 6
    logic signed [ACC_W-1:0]  r_s6_off, r_s6_sens;
    logic signed [T_W-1:0]    r_s6_temp;
    logic [RAW_W-1:0]         r_s6_d1;
    // stage 7
    logic signed [PP_W-1:0]   r_pl, n_pl, r_ph, n_ph;
    logic signed [ACC_W-1:0]  r_s7_off;
    logic signed [T_W-1:0]    r_s7_temp;
    // stage 8
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_s8_off;
    logic signed [T_W-1:0]    r_s8_temp;
    // stage 9 (output)
    logic signed [X_W-1:0]    x_pres;
    logic signed [T_W-1:0]    temp_clamp;
    logic [PRES_O_W-1:0]      n_pres;
    logic signed [TEMP_O_W-1:0] r_out_temp;
    logic [PRES_O_W-1:0]      r_out_pres;

    // Calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) r_cal[i] <= '0;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(CFG_N))) begin
            r_cal[i_cfg_index] <= i_cfg_data;
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves on
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG-2; k >= 0; k--) en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_comb begin
        // dT = D2 - C5 * 256, fits 25 bits signed
        n_s1_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, r_cal[CFG_REFERENCE_TEMP], 8'h00});

        n_p_c6 = r_s1_dt * $signed({1'b0, r_cal[CFG_TEMP_COEFF]});
        n_p_c4 = r_s1_dt * $signed({1'b0, r_cal[CFG_OFF_TEMP_COEFF]});
        n_p_c3 = r_s1_dt * $signed({1'b0, r_cal[CFG_SENS_TEMP_COEFF]});
        n_p_dd = r_s1_dt * r_s1_dt;

        n_s3_temp = TEMP_REF + T_W'(r_p_c6 >>> 23);
        n_s3_off  = $signed(ACC_W'({r_cal[CFG_PRESSURE_OFFSET], 16'h0000}))
                  + ACC_W'(r_p_c4 >>> 7);
        n_s3_sens = $signed(ACC_W'({r_cal[CFG_PRESSURE_SENS], 15'h0000}))
                  + ACC_W'(r_p_c3 >>> 8);
        n_s3_t2   = T_W'(r_p_dd >>> 31);

        diff_a = r_s3_temp - TEMP_REF;
        diff_b = r_s3_temp + TEMP_COLD;
        n_s4_a = diff_a * diff_a;
        n_s4_b = diff_b * diff_b;

        // second-order terms; the cold terms are floored separately
        n_s5_off2  = '0;
        n_s5_sens2 = '0;
        if (r_s4_lt) begin
            n_s5_off2  = ((r_s4_a <<< 2) + r_s4_a) >>> 1;
            n_s5_sens2 = ((r_s4_a <<< 2) + r_s4_a) >>> 2;
            if (r_s4_cold) begin
                n_s5_off2  = n_s5_off2 + ((r_s4_b <<< 3) - r_s4_b);
                n_s5_sens2 = n_s5_sens2
                           + (((r_s4_b <<< 3) + (r_s4_b <<< 1) + r_s4_b) >>> 1);
            end
        end
        n_s5_temp = r_s4_lt ? (r_s4_temp - r_s4_t2) : r_s4_temp;

        // D1 x SENS as two narrower products
        n_pl = $signed({1'b0, r_s6_d1}) * $signed({1'b0, r_s6_sens[HALF_W-1:0]});
        n_ph = $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[ACC_W-1:HALF_W]);

        n_prod = (PROD_W'(r_ph) <<< HALF_W) + PROD_W'(r_pl);

        x_pres = X_W'(r_prod >>> 21) - X_W'(r_s8_off);
        if (x_pres < 0)
            n_pres = '0;
        else if (x_pres[X_W-1:PRES_O_W+15] != '0)
            n_pres = '1;
        else
            n_pres = x_pres[PRES_O_W+14:15];

        if (r_s8_temp < TEMP_SAT_LO)
            temp_clamp = TEMP_SAT_LO;
        else if (r_s8_temp > TEMP_SAT_HI)
            temp_clamp = TEMP_SAT_HI;
        else
            temp_clamp = r_s8_temp;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= i_raw_pressure;
        end
        if (en[1]) begin
            r_p_c6  <= n_p_c6;
            r_p_c4  <= n_p_c4;
            r_p_c3  <= n_p_c3;
            r_p_dd  <= n_p_dd;
            r_s2_d1 <= r_s1_d1;
        end
        if (en[2]) begin
            r_s3_temp <= n_s3_temp;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_t2   <= n_s3_t2;
            r_s3_d1   <= r_s2_d1;
        end
        if (en[3]) begin
            r_s4_a    <= n_s4_a;
            r_s4_b    <= n_s4_b;
            r_s4_lt   <= r_s3_temp < TEMP_REF;
            r_s4_cold <= r_s3_temp < -TEMP_COLD;
            r_s4_temp <= r_s3_temp;
            r_s4_t2   <= r_s3_t2;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_d1   <= r_s3_d1;
        end
        if (en[4]) begin
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_temp  <= n_s5_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_d1    <= r_s4_d1;
        end
        if (en[5]) begin
            r_s6_off  <= r_s5_off - r_s5_off2;
            r_s6_sens <= r_s5_sens - r_s5_sens2;
            r_s6_temp <= r_s5_temp;
            r_s6_d1   <= r_s5_d1;
        end
        if (en[6]) begin
            r_pl      <= n_pl;
            r_ph      <= n_ph;
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
        end
        if (en[7]) begin
            r_prod    <= n_prod;
            r_s8_off  <= r_s7_off;
            r_s8_temp <= r_s7_temp;
        end
        if (en[8]) begin
            r_out_temp <= TEMP_O_W'(temp_clamp);
            r_out_pres <= n_pres;
        end
    end

    assign o_temperature = r_out_temp;
    assign o_pressure    = r_out_pres;

`ifndef SYNTHESIS
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature >= -15'sd4000) && (o_temperature <= 15'sd8500))
        else $error("temperature outside clamp range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with a free pipeline stage");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted item not held in first stage");
`endif

endmodule

>>> sim/tb_top.sv
// Testbench for the barometric pressure compensation pipeline.
`timescale 1ns / 100ps

module tb_top
    import bpc_pkg::*;
;

    typedef struct packed {
        logic signed [TEMP_O_W-1:0] temperature;
        logic [PRES_O_W-1:0]        pressure;
    } t_reading;

    // Calibration words, index 0 in the low slice
    typedef logic [CFG_N-1:0][CAL_W-1:0] t_cal_set;

    localparam t_cal_set NOMINAL_CAL = {16'd28312, 16'd33464, 16'd23282,
                                        16'd23317, 16'd36924, 16'd40127};
    localparam longint PRESSURE_CEILING = (longint'(1) << PRES_O_W) - 1;
    localparam longint RAW_CEILING      = (longint'(1) << RAW_W) - 1;
    localparam int     QUIET_LIMIT      = 4000;
    localparam int     HOLD_OFF_CYCLES  = 300;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CAL_W-1:0]           i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [RAW_W-1:0]           i_raw_pressure;
    logic [RAW_W-1:0]           i_raw_temperature;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [TEMP_O_W-1:0] o_temperature;
    logic [PRES_O_W-1:0]        o_pressure;

    logic [CAL_W-1:0] cal_word [CFG_N];
    t_reading         expected_readings [$];
    int               fault_count    = 0;
    int               result_count   = 0;
    int               quiet_cycles   = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_off_left  = 0;

    barometric_pressure_compensation i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_temperature     (o_temperature),
        .o_pressure        (o_pressure)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // First and second order compensation in 64-bit signed maths, shifts floor
    function automatic t_reading compensate(input logic [RAW_W-1:0] raw_p,
                                            input logic [RAW_W-1:0] raw_t);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, p, a, b;
        t_reading r;
        d1 = raw_p;
        d2 = raw_t;
        c1 = cal_word[CFG_PRESSURE_SENS];
        c2 = cal_word[CFG_PRESSURE_OFFSET];
        c3 = cal_word[CFG_SENS_TEMP_COEFF];
        c4 = cal_word[CFG_OFF_TEMP_COEFF];
        c5 = cal_word[CFG_REFERENCE_TEMP];
        c6 = cal_word[CFG_TEMP_COEFF];
        dt   = d2 - c5 * 256;
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (temp < TEMP_REF) begin
            a     = (temp - TEMP_REF) * (temp - TEMP_REF);
            t2    = (dt * dt) >>> 31;
            off2  = (5 * a) >>> 1;
            sens2 = (5 * a) >>> 2;
            if (temp < -TEMP_COLD) begin
                b     = (temp + TEMP_COLD) * (temp + TEMP_COLD);
                off2  = off2 + 7 * b;
                sens2 = sens2 + ((11 * b) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (temp < TEMP_SAT_LO) temp = TEMP_SAT_LO;
        if (temp > TEMP_SAT_HI) temp = TEMP_SAT_HI;
        if (p < 0) p = 0;
        if (p > PRESSURE_CEILING) p = PRESSURE_CEILING;
        r.temperature = temp[TEMP_O_W-1:0];
        r.pressure    = p[PRES_O_W-1:0];
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that took the item
    task automatic send_item(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_readings.push_back(compensate(raw_p, raw_t));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_readings.size() != 0);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx < CFG_N) cal_word[idx] = val;
    endtask

    task automatic load_calibration(input t_cal_set words);
        wait_idle();
        for (int i = 0; i < CFG_N; i++) write_reg(CFG_IDX_W'(i), words[i]);
        i_cfg_we <= 1'b0;
    endtask

    // All words zero after reset: temperature sits at 20 degC, pressure at zero
    task automatic test_reset_calibration();
        send_item('0, '0);
        send_item('1, '1);
        send_item(24'h5A5A5A, 24'hA5A5A5);
    endtask

    task automatic test_temperature_regions();
        load_calibration(NOMINAL_CAL);
        send_item(24'd9085466, 24'd8569150);   // typical reading, above 20 degC
        send_item(24'd9085466, 24'd8566784);   // dT zero, exactly 20 degC
        send_item(24'd9085466, 24'd8566783);   // just under 20 degC, second order on
        send_item(24'd9085466, 24'd8270494);   // about 10 degC
        send_item(24'd9085466, 24'd7529764);   // exactly -15 degC, no extra term
        send_item(24'd9085466, 24'd7529763);   // just under -15 degC
        send_item(24'd9085466, 24'd0);         // temperature clamps low
        send_item(24'd9085466, '1);            // temperature clamps high
        send_item(24'd0, 24'd8569150);         // negative pressure clamps to zero
        send_item('1, 24'd8569150);
        send_item('1, 24'd0);
        send_item(24'd0, '1);
    endtask

    task automatic test_calibration_extremes();
        load_calibration('1);
        send_item('0, '0);
        send_item('1, '1);                      // pressure clamps high
        send_item('1, 24'd16776960);            // dT zero at the top reference
        // indexes past the last register must leave the words alone
        wait_idle();
        write_reg(CFG_IDX_W'(CFG_N), 16'h0000);
        write_reg(CFG_IDX_W'(CFG_N + 1), 16'h0000);
        i_cfg_we <= 1'b0;
        send_item('1, '1);
        send_item(24'h800000, 24'h7FFFFF);
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int n_sets, input int n_items);
        t_cal_set         words;
        logic [RAW_W-1:0] raw_p;
        logic [RAW_W-1:0] raw_t;
        longint           base, t, mag;
        int unsigned      k;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n_sets) begin
            for (int w = 0; w < CFG_N; w++) begin
                case ($urandom_range(9))
                    0:          words[w] = '0;
                    1:          words[w] = '1;
                    2, 3, 4, 5: words[w] = CAL_W'($urandom);
                    default:    words[w] = NOMINAL_CAL[w] + CAL_W'($urandom_range(8191))
                                           - 16'd4096;
                endcase
            end
            load_calibration(words);
            repeat (n_items) begin
                case ($urandom_range(7))
                    0:       raw_p = '0;
                    1:       raw_p = '1;
                    default: raw_p = RAW_W'($urandom);
                endcase
                // mostly near the reference point, spread on a log scale so every
                // temperature region gets hit
                if ($urandom_range(3) == 0) begin
                    raw_t = RAW_W'($urandom);
                end else begin
                    k    = $urandom_range(24);
                    mag  = $urandom & ((32'd1 << k) - 1);
                    base = cal_word[CFG_REFERENCE_TEMP];
                    base = base * 256;
                    t    = $urandom_range(1) ? base + mag : base - mag;
                    if (t < 0) t = 0;
                    if (t > RAW_CEILING) t = RAW_CEILING;
                    raw_t = t[RAW_W-1:0];
                end
                send_item(raw_p, raw_t);
            end
        end
    endtask

    // Output held off long enough for the pipeline to fill and stall its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (60) send_item(RAW_W'($urandom), RAW_W'($urandom));
    endtask

    initial begin
        for (int i = 0; i < CFG_N; i++) cal_word[i] = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_raw_pressure    <= '0;
        i_raw_temperature <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_calibration();
        test_temperature_regions();
        test_calibration_extremes();
        test_random_phase(0, 0, 3, 56);
        test_random_phase(84, 0, 3, 56);
        test_random_phase(0, 84, 3, 56);
        test_random_phase(22, 22, 3, 56);
        test_backpressure();

        wait_idle();
        repeat (2 * NSTG) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("barometric_pressure_compensation verification clean");
        end else begin
            $display("barometric_pressure_compensation verification failed");
        end
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
            end
        end
    end

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("result %0d: %s", result_count, what);
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                log_fault($sformatf("unexpected item, temperature %0d pressure %0d",
                                    o_temperature, o_pressure));
            end else begin
                want = expected_readings.pop_front();
                if (o_temperature !== want.temperature)
                    log_fault($sformatf("temperature expected %0d, got %0d",
                                        want.temperature, o_temperature));
                if (o_pressure !== want.pressure)
                    log_fault($sformatf("pressure expected %0d, got %0d",
                                        want.pressure, o_pressure));
            end
            result_count++;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("barometric_pressure_compensation verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
